/* hw/rtl/hcpp_pkg.sv */
package hcpp_pkg;

	localparam logic [7:0]  CH_HASH   = 8'h23;
	localparam logic [7:0]  CH_DASH   = 8'h2d;
	localparam logic [5:0]  CNT_MAX   = 6'd63;
	localparam logic [31:0] ERR_WORD  = 32'hffff_ffff;
	localparam logic [7:0]  OPAQUE    = 8'hff;
	localparam logic [5:0]  FMT_RGB   = 6'd3;
	localparam logic [5:0]  FMT_RRGGBB = 6'd6;
	localparam logic [5:0]  FMT_ARGB7 = 6'd7;
	localparam logic [5:0]  FMT_ARGB8 = 6'd8;

	typedef enum logic [1:0] {
		ST_VALID   = 2'd0,
		ST_RESET   = 2'd1,
		ST_INVALID = 2'd2
	} status_t;

	typedef enum logic {
		PH_IDLE   = 1'b0,
		PH_DIGITS = 1'b1
	} phase_t;

	typedef struct packed {
		status_t    status;
		logic [5:0] used;
		logic [7:0] alpha;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} token_res_t;

	// bit 4 set when the character is a hex digit, low bits give its value
	function automatic logic [4:0] hex_decode(input logic [7:0] c);
		logic [4:0] r;
		r = 5'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			r = {1'b1, c[3:0]};
		end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
			r = {1'b1, c[3:0] + 4'd9};
		end
		return r;
	endfunction

endpackage

/* hw/rtl/hex_color_parse_premultiply.sv */
// channel  | handshake                   | payload
// char     | char_valid / char_ready     | char_code[7:0], end_of_text
// result   | result_valid / result_ready | color_word[31:0], status[1:0], consumed[5:0]
//
// one character per cycle while char_ready is high; a result passes the stage 1 register, then the output register
// stage 1 parses into a register, stage 2 premultiplies into the output register
// arst_n clears phase, digit state and both valid flags
// a stalled result blocks input only once both stage registers are full
module hex_color_parse_premultiply (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        char_valid,
	output logic        char_ready,
	input  logic [7:0]  char_code,
	input  logic        end_of_text,
	output logic        result_valid,
	input  logic        result_ready,
	output logic [31:0] color_word,
	output logic [1:0]  status,
	output logic [5:0]  consumed
);

	logic                 res_valid;
	logic                 res_ready;
	hcpp_pkg::token_res_t res;

	hcpp_parse u_parse (
		.clk         (clk),
		.arst_n      (arst_n),
		.char_valid  (char_valid),
		.char_ready  (char_ready),
		.char_code   (char_code),
		.end_of_text (end_of_text),
		.res_valid   (res_valid),
		.res         (res),
		.res_ready   (res_ready)
	);

	hcpp_premul u_premul (
		.clk          (clk),
		.arst_n       (arst_n),
		.res_valid    (res_valid),
		.res          (res),
		.res_ready    (res_ready),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.color_word   (color_word),
		.status       (status),
		.consumed     (consumed)
	);

endmodule

/* hw/rtl/hcpp_parse.sv */
module hcpp_parse (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  char_valid,
	output logic                  char_ready,
	input  logic [7:0]            char_code,
	input  logic                  end_of_text,
	output logic                  res_valid,
	output hcpp_pkg::token_res_t  res,
	input  logic                  res_ready
);

	hcpp_pkg::phase_t     phase_q, phase_d;
	logic [31:0]          acc_q, acc_d;
	logic [5:0]           cnt_q, cnt_d;
	logic                 s1_valid_q;
	hcpp_pkg::token_res_t s1_q;

	logic                 hit;
	logic [4:0]           hexd;
	logic [31:0]          acc_shift;
	logic [5:0]           cnt_inc;
	logic                 emit, direct;
	hcpp_pkg::status_t    dstat;
	logic [5:0]           dused;
	logic [31:0]          fin_acc;
	logic [5:0]           fin_cnt;
	hcpp_pkg::token_res_t res_d;

	assign char_ready = !s1_valid_q || res_ready;
	assign hit        = char_valid && char_ready;
	assign hexd       = hcpp_pkg::hex_decode(char_code);
	assign acc_shift  = {acc_q[27:0], hexd[3:0]};
	assign cnt_inc    = (cnt_q == hcpp_pkg::CNT_MAX) ? hcpp_pkg::CNT_MAX : cnt_q + 6'd1;

	// next phase
	always_comb begin
		phase_d = phase_q;
		unique case (phase_q)
			hcpp_pkg::PH_IDLE: begin
				if (char_code == hcpp_pkg::CH_HASH && !end_of_text) begin
					phase_d = hcpp_pkg::PH_DIGITS;
				end
			end
			hcpp_pkg::PH_DIGITS: begin
				if (!hexd[4] || end_of_text) begin
					phase_d = hcpp_pkg::PH_IDLE;
				end
			end
			default: phase_d = hcpp_pkg::PH_IDLE;
		endcase
	end

	// token outputs and digit state
	always_comb begin
		emit    = 1'b0;
		direct  = 1'b0;
		dstat   = hcpp_pkg::ST_INVALID;
		dused   = 6'd0;
		fin_acc = acc_q;
		fin_cnt = cnt_q;
		acc_d   = acc_q;
		cnt_d   = cnt_q;
		unique case (phase_q)
			hcpp_pkg::PH_IDLE: begin
				acc_d = 32'd0;
				cnt_d = 6'd0;
				if (char_code == hcpp_pkg::CH_DASH) begin
					emit   = 1'b1;
					direct = 1'b1;
					dstat  = hcpp_pkg::ST_RESET;
					dused  = 6'd1;
				end else if (char_code != hcpp_pkg::CH_HASH) begin
					emit   = 1'b1;
					direct = 1'b1;
				end else if (end_of_text) begin
					emit    = 1'b1;
					fin_acc = 32'd0;
					fin_cnt = 6'd0;
				end
			end
			hcpp_pkg::PH_DIGITS: begin
				if (!hexd[4]) begin
					emit = 1'b1;
				end else begin
					acc_d = acc_shift;
					cnt_d = cnt_inc;
					if (end_of_text) begin
						emit    = 1'b1;
						fin_acc = acc_shift;
						fin_cnt = cnt_inc;
					end
				end
			end
			default: begin
				acc_d = 32'd0;
				cnt_d = 6'd0;
			end
		endcase
		if (emit) begin
			acc_d = 32'd0;
			cnt_d = 6'd0;
		end
	end

	// format selection by digit count
	always_comb begin
		res_d.status = hcpp_pkg::ST_VALID;
		res_d.used   = (fin_cnt == hcpp_pkg::CNT_MAX) ? hcpp_pkg::CNT_MAX : fin_cnt + 6'd1;
		res_d.alpha  = fin_acc[31:24];
		res_d.red    = fin_acc[23:16];
		res_d.green  = fin_acc[15:8];
		res_d.blue   = fin_acc[7:0];
		case (fin_cnt)
			hcpp_pkg::FMT_RGB: begin
				res_d.alpha = hcpp_pkg::OPAQUE;
				res_d.red   = {fin_acc[11:8], fin_acc[11:8]};
				res_d.green = {fin_acc[7:4], fin_acc[7:4]};
				res_d.blue  = {fin_acc[3:0], fin_acc[3:0]};
			end
			hcpp_pkg::FMT_RRGGBB: begin
				res_d.alpha = hcpp_pkg::OPAQUE;
			end
			hcpp_pkg::FMT_ARGB7, hcpp_pkg::FMT_ARGB8: begin
				res_d.alpha = fin_acc[31:24];
			end
			default: begin
				res_d.status = hcpp_pkg::ST_INVALID;
			end
		endcase
		if (direct) begin
			res_d.status = dstat;
			res_d.used   = dused;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= hcpp_pkg::PH_IDLE;
			acc_q      <= 32'd0;
			cnt_q      <= 6'd0;
			s1_valid_q <= 1'b0;
		end else begin
			if (hit) begin
				phase_q <= phase_d;
				acc_q   <= acc_d;
				cnt_q   <= cnt_d;
			end
			if (hit && emit) begin
				s1_valid_q <= 1'b1;
			end else if (res_ready) begin
				s1_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (hit && emit) begin
			s1_q <= res_d;
		end
	end

	assign res_valid = s1_valid_q;
	assign res       = s1_q;

`ifndef ASSERT_OFF
	a_dash_resets: assert property (@(posedge clk) disable iff (!arst_n)
		hit && phase_q == hcpp_pkg::PH_IDLE && char_code == hcpp_pkg::CH_DASH
		|=> s1_valid_q && s1_q.status == hcpp_pkg::ST_RESET && s1_q.used == 6'd1)
		else $error("reset marker did not give a reset result");
	a_emit_clears: assert property (@(posedge clk) disable iff (!arst_n)
		hit && emit |=> phase_q == hcpp_pkg::PH_IDLE && cnt_q == 6'd0 && acc_q == 32'd0)
		else $error("token state not cleared after result");
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_q && !res_ready |=> s1_valid_q && $stable(s1_q))
		else $error("stalled parse result changed");
`endif

endmodule

/* hw/rtl/hcpp_premul.sv */
module hcpp_premul (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 res_valid,
	input  hcpp_pkg::token_res_t res,
	output logic                 res_ready,
	output logic                 result_valid,
	input  logic                 result_ready,
	output logic [31:0]          color_word,
	output logic [1:0]           status,
	output logic [5:0]           consumed
);

	logic        out_valid_q;
	logic [31:0] word_q;
	logic [1:0]  status_q;
	logic [5:0]  used_q;
	logic        load;
	logic [15:0] pr, pg, pb;
	logic [16:0] sr, sg, sb;
	logic [31:0] word_d;

	assign res_ready = !out_valid_q || result_ready;
	assign load      = res_valid && res_ready;

	// x / 255 for x up to 255 * 255 as (x + (x >> 8) + 1) >> 8
	assign pr = res.red * res.alpha;
	assign pg = res.green * res.alpha;
	assign pb = res.blue * res.alpha;
	assign sr = {1'b0, pr} + {9'd0, pr[15:8]} + 17'd1;
	assign sg = {1'b0, pg} + {9'd0, pg[15:8]} + 17'd1;
	assign sb = {1'b0, pb} + {9'd0, pb[15:8]} + 17'd1;

	always_comb begin
		if (res.status == hcpp_pkg::ST_VALID) begin
			word_d = {res.alpha, sr[15:8], sg[15:8], sb[15:8]};
		end else begin
			word_d = hcpp_pkg::ERR_WORD;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (result_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			word_q   <= word_d;
			status_q <= res.status;
			used_q   <= res.used;
		end
	end

	assign result_valid = out_valid_q;
	assign color_word   = word_q;
	assign status       = status_q;
	assign consumed     = used_q;

`ifndef ASSERT_OFF
	a_err_word: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && status_q != hcpp_pkg::ST_VALID |-> word_q == hcpp_pkg::ERR_WORD)
		else $error("error result without all-ones word");
	a_zero_alpha: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && status_q == hcpp_pkg::ST_VALID && word_q[31:24] == 8'd0
		|-> word_q == 32'd0)
		else $error("zero alpha did not give zero word");
`endif

endmodule
